/* hw/rtl/oaht_pkg.sv */
// Shared types and constants of the open-addressing hash table.
// Used by oaht_ctrl, oaht_dp and open_addressing_hash_table; no dependencies.
package oaht_pkg;

  localparam int TABLE_DEPTH = 64;
  localparam int KEY_W       = 32;
  localparam int SLOT_W      = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int CMD_W       = 2;
  localparam int STEP_W      = 6;              // step_prime, c1, c2
  localparam int SUM_W       = STEP_W + 1;     // c1+c2, 2*c2, stride
  localparam int HASH_STEPS  = KEY_W;          // one key bit per cycle
  localparam int STEP_STEPS  = SUM_W;          // one bit per cycle
  localparam int OUT_DATA_W  = ((SLOT_W + 7) / 8) * 8;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 7;

  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_SEARCH = 2'd1;
  localparam logic [CMD_W-1:0] CMD_DELETE = 2'd2;
  localparam logic [CMD_W-1:0] CMD_NOP    = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_PROBE_MODE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TABLE_SIZE   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LINEAR_COEFF = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SQUARE_COEFF = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_PRIME   = 3'd4;

  // Effective configuration, already clamped.
  typedef struct packed {
    logic              mode;   // 1: double hashing
    logic [CNT_W-1:0]  m;      // 1 .. TABLE_DEPTH
    logic [STEP_W-1:0] c1;
    logic [STEP_W-1:0] c2;
    logic [STEP_W-1:0] r;      // 1 .. 63
  } cfg_t;

  typedef struct packed {
    logic load;
    logic hash_en;
    logic step_load;
    logic step_en;
    logic probe_start;
    logic probe_en;
    logic commit;
    logic out_load;
  } ctl_cmd_t;

  typedef struct packed {
    logic in_nop;
    logic hash_last;
    logic step_last;
    logic probe_done;
    logic out_free;
  } ctl_sts_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_HASH,
    S_SETUP,
    S_STEP,
    S_PRIME,
    S_PROBE,
    S_DONE
  } state_t;

endpackage

/* hw/rtl/oaht_ctrl.sv */
// Controller state machine of the hash table: sequences hashing, step
// reduction, probing and result hand-off. Depends on oaht_pkg.
module oaht_ctrl
  import oaht_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_tvalid,
  output logic     in_tready,
  input  ctl_sts_t sts,
  output ctl_cmd_t cmd
);

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          state_nxt = sts.in_nop ? S_DONE : S_HASH;
        end
      end
      S_HASH: begin
        if (sts.hash_last) begin
          state_nxt = S_SETUP;
        end
      end
      S_SETUP: state_nxt = S_STEP;
      S_STEP: begin
        if (sts.step_last) begin
          state_nxt = S_PRIME;
        end
      end
      S_PRIME: state_nxt = S_PROBE;
      S_PROBE: begin
        if (sts.probe_done) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (sts.out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        cmd.load  = in_tvalid;
      end
      S_HASH:  cmd.hash_en     = 1'b1;
      S_SETUP: cmd.step_load   = 1'b1;
      S_STEP:  cmd.step_en     = 1'b1;
      S_PRIME: cmd.probe_start = 1'b1;
      S_PROBE: begin
        cmd.probe_en = 1'b1;
        cmd.commit   = sts.probe_done;
      end
      S_DONE:  cmd.out_load    = sts.out_free;
      default: cmd = '0;
    endcase
  end

endmodule

/* hw/rtl/oaht_dp.sv */
// Datapath of the hash table: bit-serial remainder lanes, probe position
// stepping, key store, slot valid bits and output register. Depends on oaht_pkg.
module oaht_dp
  import oaht_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  cfg_t              cfg,
  input  ctl_cmd_t          cmd,
  output ctl_sts_t          sts,
  input  logic [KEY_W-1:0]  in_key,
  input  logic [CMD_W-1:0]  in_cmd,
  input  logic              out_tready,
  output logic              out_tvalid,
  output logic              out_success,
  output logic [SLOT_W-1:0] out_slot
);

  // rem < mod <= TABLE_DEPTH, so {rem, bit} stays below 2*mod
  function automatic logic [SLOT_W-1:0] red_bit(input logic [SLOT_W-1:0] rem,
                                                input logic b,
                                                input logic [CNT_W-1:0] md);
    logic [CNT_W-1:0] t;
    t = {rem, b};
    if (t >= md) begin
      t = t - md;
    end
    return t[SLOT_W-1:0];
  endfunction

  function automatic logic [SLOT_W-1:0] add_mod(input logic [SLOT_W-1:0] a,
                                                input logic [SLOT_W-1:0] b,
                                                input logic [CNT_W-1:0] md);
    logic [CNT_W-1:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= md) begin
      s = s - md;
    end
    return s[SLOT_W-1:0];
  endfunction

  logic [KEY_W-1:0]       key_r;
  logic [CMD_W-1:0]       op_r;
  logic [KEY_W-1:0]       sha_r;
  logic [KEY_W-1:0]       shb_r;
  logic [SLOT_W-1:0]      ra_r;
  logic [SLOT_W-1:0]      rb_r;
  logic [SLOT_W-1:0]      base_r;
  logic [CNT_W-1:0]       cnt_r;
  logic [SLOT_W-1:0]      pos_r;
  logic [SLOT_W-1:0]      d_r;
  logic [SLOT_W-1:0]      dd_r;
  logic [SLOT_W-1:0]      addr_q_r;
  logic                   iss_v_r;
  logic [KEY_W-1:0]       rd_key_r;
  logic                   rd_vld_r;
  logic [TABLE_DEPTH-1:0] vld_r;
  logic                   res_ok_r;
  logic [SLOT_W-1:0]      res_slot_r;
  logic                   out_v_r;
  logic                   out_ok_r;
  logic [SLOT_W-1:0]      out_slot_r;

  logic [KEY_W-1:0] key_store [TABLE_DEPTH];

  logic [CNT_W-1:0]  modb;
  logic [STEP_W-1:0] stride;
  logic [SUM_W-1:0]  val_a;
  logic [SUM_W-1:0]  val_b;
  logic              iss;
  logic              hit;
  logic              last;

  // lane B divides by r while hashing, by m during step reduction
  assign modb   = cmd.step_en ? cfg.m : {1'b0, cfg.r};
  assign stride = cfg.r - rb_r;
  assign val_a  = cfg.mode ? {1'b0, stride} : ({1'b0, cfg.c1} + {1'b0, cfg.c2});
  assign val_b  = cfg.mode ? '0 : {cfg.c2, 1'b0};

  assign iss  = cmd.probe_en && (cnt_r < cfg.m);
  assign hit  = iss_v_r && ((op_r == CMD_INSERT) ? !rd_vld_r
                                                 : (rd_vld_r && (rd_key_r == key_r)));
  assign last = iss_v_r && (cnt_r == cfg.m);

  assign sts.in_nop     = (in_cmd == CMD_NOP);
  assign sts.hash_last  = (cnt_r == CNT_W'(HASH_STEPS - 1));
  assign sts.step_last  = (cnt_r == CNT_W'(STEP_STEPS - 1));
  assign sts.probe_done = hit || last;
  assign sts.out_free   = !out_v_r || out_tready;

  // operand shift lanes and remainders
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      key_r <= in_key;
      op_r  <= in_cmd;
      sha_r <= in_key;
      shb_r <= in_key;
      ra_r  <= '0;
      rb_r  <= '0;
    end else if (cmd.hash_en || cmd.step_en) begin
      ra_r  <= red_bit(ra_r, sha_r[KEY_W-1], cfg.m);
      rb_r  <= red_bit(rb_r, shb_r[KEY_W-1], modb);
      sha_r <= {sha_r[KEY_W-2:0], 1'b0};
      shb_r <= {shb_r[KEY_W-2:0], 1'b0};
    end else if (cmd.step_load) begin
      base_r <= ra_r;
      sha_r  <= {val_a, {(KEY_W - SUM_W){1'b0}}};
      shb_r  <= {val_b, {(KEY_W - SUM_W){1'b0}}};
      ra_r   <= '0;
      rb_r   <= '0;
    end
  end

  // probe sequence: pos advances by d, d advances by dd (quadratic) or 0
  always_ff @(posedge clk) begin
    if (cmd.probe_start) begin
      pos_r <= base_r;
      d_r   <= ra_r;
      dd_r  <= rb_r;
    end else if (iss) begin
      pos_r    <= add_mod(pos_r, d_r, cfg.m);
      d_r      <= add_mod(d_r, dd_r, cfg.m);
      addr_q_r <= pos_r;
      rd_vld_r <= vld_r[pos_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r   <= '0;
      iss_v_r <= 1'b0;
    end else begin
      iss_v_r <= iss;
      if (cmd.load || cmd.step_load || cmd.probe_start) begin
        cnt_r <= '0;
      end else if (cmd.hash_en || cmd.step_en || iss) begin
        cnt_r <= cnt_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit && hit && (op_r == CMD_INSERT)) begin
      key_store[addr_q_r] <= key_r;
    end
    if (iss) begin
      rd_key_r <= key_store[pos_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (cmd.commit && hit) begin
      if (op_r == CMD_INSERT) begin
        vld_r[addr_q_r] <= 1'b1;
      end else if (op_r == CMD_DELETE) begin
        vld_r[addr_q_r] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      res_ok_r   <= 1'b0;
      res_slot_r <= '0;
    end else if (cmd.commit) begin
      res_ok_r   <= hit;
      res_slot_r <= hit ? addr_q_r : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_v_r <= 1'b1;
    end else if (out_tready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_ok_r   <= res_ok_r;
      out_slot_r <= res_slot_r;
    end
  end

  assign out_tvalid  = out_v_r;
  assign out_success = out_ok_r;
  assign out_slot    = out_slot_r;

endmodule

/* hw/rtl/open_addressing_hash_table.sv */
// Open-addressing hash table of 32-bit keys, 64 slots. Each command takes
// one input transfer and gives one result transfer. Steps per command:
// accept, the bit-serial key mod m / key mod r lanes, reduction of the
// probe step terms mod m, then one slot read per cycle on the single key
// store read port, up to m probes plus a compare, then hand-off of the
// result to the output register. An unused command (3) skips hashing
// and probing and goes straight to the hand-off. One command is in
// flight at a time; a finished result sits in the output register while
// the next command is taken.
// Depends on oaht_pkg, oaht_ctrl and oaht_dp.
module open_addressing_hash_table
  import oaht_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  // command channel
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [KEY_W-1:0]      in_tdata,   // [31:0] key
  input  logic [CMD_W-1:0]      in_tuser,   // [1:0] cmd
  // result channel
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // [5:0] slot, [7:6] zero
  output logic [0:0]            out_tuser,  // [0] success
  // configuration write channel
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  // Configuration registers, to be written by the user only while the table is idle; the block does not enforce this.
  logic              probe_mode_r;
  logic [6:0]        table_size_r;
  logic [STEP_W-1:0] linear_coeff_r;
  logic [STEP_W-1:0] square_coeff_r;
  logic [STEP_W-1:0] step_prime_r;

  cfg_t     cfg;
  ctl_cmd_t ctl_cmd;
  ctl_sts_t ctl_sts;
  logic              res_success;
  logic [SLOT_W-1:0] res_slot;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      probe_mode_r   <= 1'b0;
      table_size_r   <= 7'd64;
      linear_coeff_r <= 6'd1;
      square_coeff_r <= 6'd1;
      step_prime_r   <= 6'd61;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_PROBE_MODE:   probe_mode_r   <= cfg_data[0];
        REG_TABLE_SIZE:   table_size_r   <= cfg_data;
        REG_LINEAR_COEFF: linear_coeff_r <= cfg_data[STEP_W-1:0];
        REG_SQUARE_COEFF: square_coeff_r <= cfg_data[STEP_W-1:0];
        REG_STEP_PRIME:   step_prime_r   <= cfg_data[STEP_W-1:0];
        default: ;  // writes past the register list are dropped
      endcase
    end
  end

  // Clamp: m of 0 acts as 1, m above the table depth acts as the depth;
  // a step prime of 0 acts as 1.
  always_comb begin
    cfg.mode = probe_mode_r;
    cfg.c1   = linear_coeff_r;
    cfg.c2   = square_coeff_r;
    cfg.r    = (step_prime_r == '0) ? STEP_W'(1) : step_prime_r;
    priority if (table_size_r == '0) begin
      cfg.m = CNT_W'(1);
    end else if (table_size_r > 7'(TABLE_DEPTH)) begin
      cfg.m = CNT_W'(TABLE_DEPTH);
    end else begin
      cfg.m = table_size_r[CNT_W-1:0];
    end
  end

  oaht_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (ctl_sts),
    .cmd       (ctl_cmd)
  );

  oaht_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg),
    .cmd         (ctl_cmd),
    .sts         (ctl_sts),
    .in_key      (in_tdata),
    .in_cmd      (in_tuser),
    .out_tready  (out_tready),
    .out_tvalid  (out_tvalid),
    .out_success (res_success),
    .out_slot    (res_slot)
  );

  assign out_tdata    = {{(OUT_DATA_W - SLOT_W){1'b0}}, res_slot};
  assign out_tuser[0] = res_success;

  // A new result appears only from the controller's hand-off.
  a_out_from_load: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(ctl_cmd.out_load))
    else $error("result appeared without hand-off");

  // A failed command always reports slot zero.
  a_fail_slot_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser[0]) |-> (out_tdata == '0))
    else $error("failed result with nonzero slot");

  // One command at a time: busy right after a command transfer.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("command taken while busy");

endmodule

/* test/oaht_checker.sv */
// Result checker for open_addressing_hash_table: keeps its own copy of the
// slot table and registers, predicts each command's answer, compares results.
// Depends on oaht_pkg.
module oaht_checker
  import oaht_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  input  logic                  in_tready,
  input  logic [KEY_W-1:0]      in_tdata,
  input  logic [CMD_W-1:0]      in_tuser,
  input  logic                  out_tvalid,
  input  logic                  out_tready,
  input  logic [OUT_DATA_W-1:0] out_tdata,
  input  logic [0:0]            out_tuser,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int unsigned           fail_count,
  output int unsigned           results_due
);

  typedef struct {
    logic [CMD_W-1:0]  cmd;
    logic [KEY_W-1:0]  key;
    logic              found;
    logic [SLOT_W-1:0] slot;
  } answer_t;

  logic [KEY_W-1:0]      stored_key [TABLE_DEPTH];
  logic                  occupied   [TABLE_DEPTH];
  logic                  dbl_hash;
  logic [CFG_DATA_W-1:0] size_reg;
  logic [STEP_W-1:0]     c1_reg;
  logic [STEP_W-1:0]     c2_reg;
  logic [STEP_W-1:0]     prime_reg;
  answer_t               pending_answers [$];

  initial begin
    fail_count  = 0;
    results_due = 0;
  end

  task automatic report(string what);
    $display("MISMATCH @%0t: %s", $time, what);
    fail_count++;
  endtask

  // modulus after clamping: 0 acts as 1, above depth acts as depth
  function automatic longint unsigned slots_in_use();
    if (size_reg == 0) return 1;
    if (size_reg > TABLE_DEPTH) return TABLE_DEPTH;
    return size_reg;
  endfunction

  function automatic longint unsigned probe_slot(longint unsigned k, longint unsigned i,
                                                 longint unsigned m);
    longint unsigned r;
    if (dbl_hash) begin
      r = (prime_reg == 0) ? 1 : prime_reg;
      return (k % m + (i * (r - k % r)) % m) % m;
    end
    return (k % m + i * c1_reg + i * i * c2_reg) % m;
  endfunction

  // applies one command to the table copy and returns its answer
  function automatic answer_t run_command(logic [CMD_W-1:0] cmd, logic [KEY_W-1:0] key);
    answer_t         ans;
    longint unsigned m;
    longint unsigned p;
    ans.cmd   = cmd;
    ans.key   = key;
    ans.found = 1'b0;
    ans.slot  = '0;
    m = slots_in_use();
    for (int i = 0; i < m && !ans.found; i++) begin
      p = probe_slot(key, i, m);
      case (cmd)
        CMD_INSERT: begin
          if (!occupied[p[SLOT_W-1:0]]) begin
            stored_key[p[SLOT_W-1:0]] = key;
            occupied[p[SLOT_W-1:0]]   = 1'b1;
            ans.found                 = 1'b1;
            ans.slot                  = p[SLOT_W-1:0];
          end
        end
        CMD_SEARCH, CMD_DELETE: begin
          // no early stop at an empty slot: full scan
          if (occupied[p[SLOT_W-1:0]] && stored_key[p[SLOT_W-1:0]] == key) begin
            ans.found = 1'b1;
            ans.slot  = p[SLOT_W-1:0];
          end
        end
        default: ;
      endcase
    end
    if (ans.found && cmd == CMD_DELETE) occupied[ans.slot] = 1'b0;
    return ans;
  endfunction

  always @(posedge clk) begin : watch
    answer_t want;
    if (!rst_n) begin
      occupied  = '{default: 1'b0};
      dbl_hash  = 1'b0;
      size_reg  = 64;
      c1_reg    = 1;
      c2_reg    = 1;
      prime_reg = 61;
      pending_answers.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        if (pending_answers.size() == 0) begin
          report($sformatf("unexpected result transfer: success %0b slot %0d",
                           out_tuser[0], out_tdata[SLOT_W-1:0]));
        end else begin
          want = pending_answers.pop_front();
          if (out_tuser[0] !== want.found)
            report($sformatf("cmd %0d key %h: success %0b, want %0b",
                             want.cmd, want.key, out_tuser[0], want.found));
          if (out_tdata[SLOT_W-1:0] !== want.slot)
            report($sformatf("cmd %0d key %h: slot %0d, want %0d",
                             want.cmd, want.key, out_tdata[SLOT_W-1:0], want.slot));
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_PROBE_MODE:   dbl_hash  = cfg_data[0];
          REG_TABLE_SIZE:   size_reg  = cfg_data;
          REG_LINEAR_COEFF: c1_reg    = cfg_data[STEP_W-1:0];
          REG_SQUARE_COEFF: c2_reg    = cfg_data[STEP_W-1:0];
          REG_STEP_PRIME:   prime_reg = cfg_data[STEP_W-1:0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready)
        pending_answers.push_back(run_command(in_tuser, in_tdata));
    end
    results_due = pending_answers.size();
  end

endmodule

/* test/testbench.sv */
// Top of the open_addressing_hash_table test: clock, reset, command and
// register stimulus, result back-pressure and the verdict.
// Depends on oaht_pkg, open_addressing_hash_table and oaht_checker.
module testbench;
  import oaht_pkg::*;

  // ~525 commands, each with its gap and result stall: far below this
  localparam int unsigned CYCLE_LIMIT = 500000;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [KEY_W-1:0]      in_tdata   = '0;   // [31:0] key
  logic [CMD_W-1:0]      in_tuser   = '0;   // [1:0] cmd
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;         // [5:0] slot, [7:6] zero
  logic [0:0]            out_tuser;         // [0] success
  logic                  cfg_valid  = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index  = '0;
  logic [CFG_DATA_W-1:0] cfg_data   = '0;

  int unsigned fail_count;
  int unsigned results_due;
  int unsigned cycles = 0;
  logic        calm   = 1'b0;   // set: neither side idles
  logic [KEY_W-1:0] key_pool [8];

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  open_addressing_hash_table uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  oaht_checker result_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .fail_count  (fail_count),
    .results_due (results_due)
  );

  // Hang guard.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  function automatic int unsigned pick_gap();
    return calm ? 0 : $urandom_range(0, 4);
  endfunction

  // insert-heavy mix so the table fills; deletes keep it churning
  function automatic logic [CMD_W-1:0] pick_cmd();
    int unsigned roll;
    roll = $urandom_range(0, 19);
    if (roll < 8)  return CMD_INSERT;
    if (roll < 13) return CMD_SEARCH;
    if (roll < 18) return CMD_DELETE;
    return CMD_NOP;
  endfunction

  // a quarter tiny tables (full-table cases), a quarter corners, half anything
  function automatic logic [CFG_DATA_W-1:0] pick_size();
    case ($urandom_range(0, 3))
      0: return CFG_DATA_W'($urandom_range(2, 8));
      1: begin
        case ($urandom_range(0, 5))
          0: return 0;
          1: return 1;
          2: return 2;
          3: return 63;
          4: return 64;
          default: return 127;
        endcase
      end
      default: return CFG_DATA_W'($urandom_range(0, 127));
    endcase
  endfunction

  // All drive tasks start and end on a falling edge. Valid stays high
  // between back-to-back commands so it is never dropped and raised in one step.
  task automatic send_command(logic [CMD_W-1:0] cmd, logic [KEY_W-1:0] key);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= key;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  // Hold off until every result is back; the block is idle after that.
  task automatic drain();
    in_tvalid <= 1'b0;
    while (results_due != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_config(logic [CFG_DATA_W-1:0] mode, logic [CFG_DATA_W-1:0] size,
                            logic [CFG_DATA_W-1:0] c1, logic [CFG_DATA_W-1:0] c2,
                            logic [CFG_DATA_W-1:0] prime);
    drain();
    write_reg(REG_PROBE_MODE, mode);
    write_reg(REG_TABLE_SIZE, size);
    write_reg(REG_LINEAR_COEFF, c1);
    write_reg(REG_SQUARE_COEFF, c2);
    write_reg(REG_STEP_PRIME, prime);
  endtask

  // Result side: either ready ahead of the result, or hold ready low until
  // the result shows and then stall for a gap from pick_gap before taking the transfer.
  initial begin : result_sink
    int unsigned stall;
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      stall = pick_gap();
      if (stall == 0) begin
        out_tready <= 1'b1;
      end else begin
        out_tready <= 1'b0;
        do @(posedge clk); while (!out_tvalid);
        repeat (stall) @(negedge clk);
        out_tready <= 1'b1;
      end
      do @(posedge clk); while (!out_tvalid);
      @(negedge clk);
    end
  end

  initial begin : stimulus
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed, reset registers: quadratic, m = 64, c1 = c2 = 1.
    send_command(CMD_SEARCH, 32'h0000_0000);   // empty table: absent
    send_command(CMD_DELETE, 32'h0000_0005);   // absent, nothing changes
    send_command(CMD_INSERT, 32'h0000_0000);
    send_command(CMD_INSERT, 32'hFFFF_FFFF);
    send_command(CMD_INSERT, 32'h0000_0040);   // collides with key 0
    send_command(CMD_INSERT, 32'h0000_0000);   // duplicate accepted
    send_command(CMD_SEARCH, 32'hFFFF_FFFF);
    send_command(CMD_DELETE, 32'h0000_0000);
    send_command(CMD_SEARCH, 32'h0000_0000);   // scan past the hole to the copy
    send_command(CMD_NOP,    32'h0000_0000);
    send_command(CMD_NOP,    32'hFFFF_FFFF);
    send_command(CMD_INSERT, 32'hA5A5_5A5A);
    send_command(CMD_INSERT, 32'h5A5A_A5A5);

    // m = 2 with zero coefficients: every probe hits one slot, so full early
    set_config(0, 2, 0, 0, 61);
    send_command(CMD_INSERT, 32'h0000_0001);
    send_command(CMD_INSERT, 32'h0000_0003);
    send_command(CMD_INSERT, 32'h0000_0005);
    send_command(CMD_SEARCH, 32'h0000_0003);

    // double hashing, size 0 taken as 1, prime 0 taken as 1
    set_config(1, 0, 0, 0, 0);
    send_command(CMD_INSERT, 32'h0000_0009);
    send_command(CMD_INSERT, 32'h0000_000A);
    send_command(CMD_DELETE, 32'h0000_0009);

    // size above depth, largest coefficients and prime
    set_config(1, 127, 63, 63, 63);
    send_command(CMD_INSERT, 32'hFFFF_FFFF);
    send_command(CMD_SEARCH, 32'hA5A5_5A5A);
    set_config(0, 64, 63, 63, 63);
    send_command(CMD_INSERT, 32'h0000_0000);
    send_command(CMD_SEARCH, 32'hFFFF_FFFF);

    // Random phases: fresh registers and key pool each; pool reuse makes
    // hits, duplicates and deletes of live keys likely.
    for (int ph = 0; ph < 10; ph++) begin
      set_config(CFG_DATA_W'($urandom_range(0, 1)), pick_size(),
                 CFG_DATA_W'($urandom_range(0, 127)),
                 CFG_DATA_W'($urandom_range(0, 127)),
                 CFG_DATA_W'($urandom_range(0, 127)));
      calm = (ph % 3 == 2);
      for (int j = 0; j < 8; j++) begin
        key_pool[3'(j)] = $urandom();
        if ($urandom_range(0, 1)) key_pool[3'(j)] &= 32'h0000_00FF;
      end
      for (int n = 0; n < 50; n++) begin
        if (n == 25 && ph % 2 == 1) drain();   // sender waits for all results
        send_command(pick_cmd(),
                     $urandom_range(0, 3) ? key_pool[3'($urandom_range(0, 7))]
                                          : $urandom());
      end
    end

    drain();
    repeat (10) @(negedge clk);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

/* files.f */
hw/rtl/oaht_pkg.sv
hw/rtl/oaht_ctrl.sv
hw/rtl/oaht_dp.sv
hw/rtl/open_addressing_hash_table.sv
test/oaht_checker.sv
test/testbench.sv
